// ===== hdl/pbbt_pkg.sv =====
// Shared types and constants for the piecewise bang-bang trajectory block.
// No dependencies; the other files that use it refer to it by scoped names.
package pbbt_pkg;

  localparam int MAX_KNOTS_DEF = 16;

  // Operation codes on the input word
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  // Derivative orders
  localparam logic [1:0] ORD_VALUE = 2'd0;
  localparam logic [1:0] ORD_VEL   = 2'd1;
  localparam logic [1:0] ORD_ACC   = 2'd2;

  localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Classified command word, front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] knot_time;
    logic [31:0] knot_value;
    logic [31:0] query_time;
    logic [1:0]  deriv_order;
  } cmd_t;

  // Back-end sequencer
  typedef enum logic [3:0] {
    B_IDLE, B_A_RD, B_A_CHK, B_Q_LAST, B_Q_LCHK, B_Q_FCHK, B_Q_SCAN,
    B_Q_SEG, B_SQ, B_SQ2, B_RSTART, B_WAIT, B_FIN
  } back_state_t;

  // Scaled-ratio unit
  typedef enum logic [2:0] {
    R_IDLE, R_MUL, R_RND, R_DIV, R_DONE
  } ratio_state_t;

endpackage

// ===== hdl/piecewise_bang_bang_trajectory.sv =====
// Clear, no-op, full append and short-table query go straight to the result register;
// held-value queries read the last and first knots; acceleration queries add a segment scan (one knot a cycle).
// Value/velocity queries and appends that change the value also run the bit-serial
// multiply and restoring divide in the ratio unit.
// One word in work at a time; a two-word queue takes input ahead of it.
// Synchronous active-low reset clears knot count, queue and output; tables undefined.
module piecewise_bang_bang_trajectory #(
  parameter int MAX_KNOTS = pbbt_pkg::MAX_KNOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_knot_time,
  input  logic signed [31:0] in_knot_value,
  input  logic [31:0]        in_query_time,
  input  logic [1:0]         in_deriv_order,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);

  logic           cmd_valid, cmd_pop;
  pbbt_pkg::cmd_t cmd;

  pbbt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_knot_time(in_knot_time),
    .in_knot_value(in_knot_value), .in_query_time(in_query_time),
    .in_deriv_order(in_deriv_order), .cmd_valid(cmd_valid),
    .cmd_pop(cmd_pop), .cmd(cmd)
  );

  pbbt_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
    .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_status(out_status)
  );

endmodule

// ===== hdl/pbbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pbbt_front.sv =====
// Front end: accepts input words, classifies the operation and queues them.
// Depends on pbbt_pkg.
module pbbt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_knot_time,
  input  logic signed [31:0]  in_knot_value,
  input  logic [31:0]         in_query_time,
  input  logic [1:0]          in_deriv_order,
  output logic                cmd_valid,
  input  logic                cmd_pop,
  output pbbt_pkg::cmd_t      cmd
);

  pbbt_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  pbbt_pkg::cmd_t cls;

  // classify the raw operation code
  always_comb begin
    unique case (in_operation)
      2'd0:    cls.op = pbbt_pkg::OP_CLEAR;
      2'd1:    cls.op = pbbt_pkg::OP_APPEND;
      2'd2:    cls.op = pbbt_pkg::OP_QUERY;
      default: cls.op = pbbt_pkg::OP_NOP;
    endcase
    cls.knot_time   = in_knot_time;
    cls.knot_value  = in_knot_value;
    cls.query_time  = in_query_time;
    cls.deriv_order = in_deriv_order;
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  // two-word queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hdl/pbbt_ratio.sv =====
// Scaled ratio unit: round(num*fac/den) on magnitudes, clamped to 2^63-1.
// Bit-serial multiply, then restoring divide one bit a cycle. Uses pbbt_pkg.
module pbbt_ratio (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [34:0] num,
  input  logic [63:0] fac,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] mag
);

  pbbt_pkg::ratio_state_t state_r, state_nxt;
  logic [34:0]  nsh_r, nsh_nxt;
  logic [127:0] fsh_r, fsh_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  den_r, den_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [62:0]  q_r, q_nxt;
  logic         big_r, big_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [63:0]  rsh;
  logic         take;

  assign rsh  = {rem_r[62:0], acc_r[127]};
  assign take = rem_r[63] || (rsh >= den_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbbt_pkg::R_IDLE: if (start) state_nxt = pbbt_pkg::R_MUL;
      pbbt_pkg::R_MUL:  if (cnt_r == 7'd0) state_nxt = pbbt_pkg::R_RND;
      pbbt_pkg::R_RND:  state_nxt = pbbt_pkg::R_DIV;
      pbbt_pkg::R_DIV:  if (cnt_r == 7'd0) state_nxt = pbbt_pkg::R_DONE;
      pbbt_pkg::R_DONE: state_nxt = pbbt_pkg::R_IDLE;
      default:          state_nxt = pbbt_pkg::R_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    nsh_nxt = nsh_r;
    fsh_nxt = fsh_r;
    acc_nxt = acc_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    big_nxt = big_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      pbbt_pkg::R_IDLE: begin
        nsh_nxt = num;
        fsh_nxt = {64'd0, fac};
        acc_nxt = '0;
        den_nxt = den;
        cnt_nxt = 7'd34;
      end
      pbbt_pkg::R_MUL: begin
        if (nsh_r[0]) acc_nxt = acc_r + fsh_r;
        nsh_nxt = nsh_r >> 1;
        fsh_nxt = fsh_r << 1;
        cnt_nxt = cnt_r - 7'd1;
      end
      pbbt_pkg::R_RND: begin
        // round to nearest: add half the divisor
        acc_nxt = acc_r + {64'd0, 1'b0, den_r[63:1]};
        rem_nxt = '0;
        q_nxt   = '0;
        big_nxt = 1'b0;
        cnt_nxt = 7'd127;
      end
      pbbt_pkg::R_DIV: begin
        acc_nxt = acc_r << 1;
        rem_nxt = take ? (rsh - den_r) : rsh;
        if (cnt_r >= 7'd63) begin
          big_nxt = big_r | take;
        end else begin
          q_nxt = {q_r[61:0], take};
        end
        cnt_nxt = cnt_r - 7'd1;
      end
      default: ;
    endcase
  end

  assign done = (state_r == pbbt_pkg::R_DONE);
  assign mag  = big_r ? pbbt_pkg::MAG_MAX : {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbbt_pkg::R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nsh_r <= nsh_nxt;
    fsh_r <= fsh_nxt;
    acc_r <= acc_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    big_r <= big_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== hdl/pbbt_back.sv =====
// Back end: knot tables, segment search, evaluation and the output register.
// Depends on pbbt_pkg, pbbt_ram and pbbt_ratio.
module pbbt_back #(
  parameter int MAX_KNOTS = pbbt_pkg::MAX_KNOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  pbbt_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);

  pbbt_pkg::back_state_t state_r, state_nxt;
  pbbt_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         i_r, i_nxt;
  logic [31:0]           t_lo_r, t_lo_nxt, t_hi_r, t_hi_nxt;
  logic signed [31:0]    v_lo_r, v_lo_nxt, v_hi_r, v_hi_nxt;
  logic [31:0]           span_r, span_nxt, s_r, s_nxt;
  logic [32:0]           dm_r, dm_nxt;
  logic                  neg_r, neg_nxt, first_r, first_nxt;
  logic [63:0]           sq_r, sq_nxt, ss_r, ss_nxt;
  logic signed [63:0]    res_r, res_nxt;
  pbbt_pkg::status_t     stat_r, stat_nxt;
  logic                  ov_r;
  logic signed [31:0]    ores_r;
  logic [1:0]            ostat_r;

  // table ports
  logic [AW-1:0]      rd_addr, wr_addr, acc_waddr;
  logic               tv_we, acc_we;
  logic [31:0]        wr_t, rd_t;
  logic signed [31:0] wr_v, rd_v;
  logic [63:0]        acc_wdata, acc_rd;

  // ratio unit
  logic        r_start, r_done;
  logic [34:0] r_num;
  logic [63:0] r_fac, r_mag;

  // shared terms
  logic               out_free, full, few, is_append;
  logic [CW-1:0]      cm1;
  logic [CW:0]        i_p2;
  logic [31:0]        kt_fix, a_span, g_span, g_tau;
  logic signed [32:0] a_df, g_df;
  logic [32:0]        a_dm, g_dm;
  logic               g_first;
  logic [31:0]        mul_a;
  logic [63:0]        mul_p;
  logic signed [63:0] part, hold_lo, hold_v, acc_s;

  pbbt_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_times (
    .clk(clk), .we(tv_we), .waddr(wr_addr), .wdata(wr_t),
    .raddr(rd_addr), .rdata(rd_t)
  );
  pbbt_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_values (
    .clk(clk), .we(tv_we), .waddr(wr_addr), .wdata(wr_v),
    .raddr(rd_addr), .rdata(rd_v)
  );
  pbbt_ram #(.WIDTH(64), .DEPTH(MAX_KNOTS)) u_accel (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(i_r), .rdata(acc_rd)
  );

  pbbt_ratio u_ratio (
    .clk(clk), .rst_n(rst_n), .start(r_start), .num(r_num),
    .fac(r_fac), .den(sq_r), .done(r_done), .mag(r_mag)
  );

  assign out_free  = !ov_r || !out_stall;
  assign full      = (count_r >= CW'(MAX_KNOTS));
  assign few       = (count_r < CW'(2));
  assign cm1       = count_r - CW'(1);
  assign i_p2      = (CW + 1)'(i_r) + (CW + 1)'(2);
  assign is_append = (cmd_r.op == pbbt_pkg::OP_APPEND);

  // append: raise a decreasing time, then span and change to previous knot
  assign kt_fix = (cmd_r.knot_time < rd_t) ? rd_t : cmd_r.knot_time;
  assign a_span = kt_fix - rd_t;
  assign a_df   = 33'(signed'(cmd_r.knot_value)) - 33'(rd_v);
  assign a_dm   = a_df[32] ? 33'(-a_df) : 33'(a_df);

  // query segment terms
  assign g_span  = t_hi_r - t_lo_r;
  assign g_tau   = cmd_r.query_time - t_lo_r;
  assign g_df    = 33'(v_hi_r) - 33'(v_lo_r);
  assign g_dm    = g_df[32] ? 33'(-g_df) : 33'(g_df);
  assign g_first = ({g_tau, 1'b0} <= {1'b0, g_span});

  // single shared 32x32 multiplier
  assign mul_a = (state_r == pbbt_pkg::B_SQ) ? span_r : s_r;
  assign mul_p = 64'(mul_a) * 64'(mul_a);

  assign part    = neg_r ? -signed'(r_mag) : signed'(r_mag);
  assign hold_lo = 64'(v_lo_r);
  assign hold_v  = 64'(rd_v);
  assign acc_s   = signed'(acc_rd);

  // ratio operands
  assign r_start = (state_r == pbbt_pkg::B_RSTART);
  always_comb begin
    if (!is_append && cmd_r.deriv_order == pbbt_pkg::ORD_VALUE) begin
      r_num = {1'b0, dm_r, 1'b0};
      r_fac = ss_r;
    end else if (is_append) begin
      r_num = {dm_r, 2'b00};
      r_fac = 64'h1_0000_0000;
    end else begin
      r_num = {dm_r, 2'b00};
      r_fac = {16'd0, s_r, 16'd0};
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbbt_pkg::B_IDLE: begin
        if (cmd_valid && out_free) begin
          priority case (cmd.op)
            pbbt_pkg::OP_APPEND:
              state_nxt = (!full && count_r != '0) ? pbbt_pkg::B_A_RD : pbbt_pkg::B_FIN;
            pbbt_pkg::OP_QUERY:
              state_nxt = few ? pbbt_pkg::B_FIN : pbbt_pkg::B_Q_LAST;
            default: state_nxt = pbbt_pkg::B_FIN;
          endcase
        end
      end
      pbbt_pkg::B_A_RD:   state_nxt = pbbt_pkg::B_A_CHK;
      pbbt_pkg::B_A_CHK:
        state_nxt = (a_span == '0 || a_df == '0) ? pbbt_pkg::B_FIN : pbbt_pkg::B_SQ;
      pbbt_pkg::B_Q_LAST: state_nxt = pbbt_pkg::B_Q_LCHK;
      pbbt_pkg::B_Q_LCHK:
        state_nxt = (cmd_r.query_time >= rd_t) ? pbbt_pkg::B_FIN : pbbt_pkg::B_Q_FCHK;
      pbbt_pkg::B_Q_FCHK:
        state_nxt = (cmd_r.query_time < rd_t) ? pbbt_pkg::B_FIN : pbbt_pkg::B_Q_SCAN;
      pbbt_pkg::B_Q_SCAN:
        if (!(i_p2 < (CW + 1)'(count_r) && cmd_r.query_time > rd_t))
          state_nxt = pbbt_pkg::B_Q_SEG;
      pbbt_pkg::B_Q_SEG: begin
        if (g_span == '0 || g_df == '0 || cmd_r.deriv_order == pbbt_pkg::ORD_ACC ||
            (cmd_r.deriv_order != pbbt_pkg::ORD_VALUE &&
             cmd_r.deriv_order != pbbt_pkg::ORD_VEL)) begin
          state_nxt = pbbt_pkg::B_FIN;
        end else begin
          state_nxt = pbbt_pkg::B_SQ;
        end
      end
      pbbt_pkg::B_SQ:
        state_nxt = (is_append || cmd_r.deriv_order != pbbt_pkg::ORD_VALUE) ?
                    pbbt_pkg::B_RSTART : pbbt_pkg::B_SQ2;
      pbbt_pkg::B_SQ2:    state_nxt = pbbt_pkg::B_RSTART;
      pbbt_pkg::B_RSTART: state_nxt = pbbt_pkg::B_WAIT;
      pbbt_pkg::B_WAIT:   if (r_done) state_nxt = pbbt_pkg::B_FIN;
      pbbt_pkg::B_FIN:    state_nxt = pbbt_pkg::B_IDLE;
      default:            state_nxt = pbbt_pkg::B_IDLE;
    endcase
  end

  // register updates and table controls
  always_comb begin
    cmd_nxt   = cmd_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    t_lo_nxt  = t_lo_r;
    t_hi_nxt  = t_hi_r;
    v_lo_nxt  = v_lo_r;
    v_hi_nxt  = v_hi_r;
    span_nxt  = span_r;
    s_nxt     = s_r;
    dm_nxt    = dm_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    sq_nxt    = sq_r;
    ss_nxt    = ss_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    cmd_pop   = 1'b0;
    rd_addr   = '0;
    wr_addr   = count_r[AW-1:0];
    wr_t      = kt_fix;
    wr_v      = cmd_r.knot_value;
    tv_we     = 1'b0;
    acc_we    = 1'b0;
    acc_waddr = cm1[AW-1:0];
    acc_wdata = '0;
    unique case (state_r)
      pbbt_pkg::B_IDLE: begin
        res_nxt  = '0;
        stat_nxt = pbbt_pkg::ST_OK;
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          priority case (cmd.op)
            pbbt_pkg::OP_CLEAR: count_nxt = '0;
            pbbt_pkg::OP_APPEND: begin
              if (full) begin
                stat_nxt = pbbt_pkg::ST_FULL;
              end else if (count_r == '0) begin
                // first knot: nothing to compare against
                tv_we     = 1'b1;
                wr_t      = cmd.knot_time;
                wr_v      = cmd.knot_value;
                count_nxt = CW'(1);
              end
            end
            pbbt_pkg::OP_QUERY: if (few) stat_nxt = pbbt_pkg::ST_FEW;
            default: ;
          endcase
        end
      end
      pbbt_pkg::B_A_RD: rd_addr = cm1[AW-1:0];
      pbbt_pkg::B_A_CHK: begin
        tv_we    = 1'b1;
        span_nxt = a_span;
        dm_nxt   = a_dm;
        neg_nxt  = a_df[32];
        if (a_span == '0 || a_df == '0) begin
          acc_we    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      pbbt_pkg::B_Q_LAST: rd_addr = cm1[AW-1:0];
      pbbt_pkg::B_Q_LCHK: begin
        rd_addr = '0;
        if (cmd_r.query_time >= rd_t)
          res_nxt = (cmd_r.deriv_order == pbbt_pkg::ORD_VALUE) ? hold_v : '0;
      end
      pbbt_pkg::B_Q_FCHK: begin
        rd_addr  = AW'(1);
        t_lo_nxt = rd_t;
        v_lo_nxt = rd_v;
        i_nxt    = '0;
        if (cmd_r.query_time < rd_t)
          res_nxt = (cmd_r.deriv_order == pbbt_pkg::ORD_VALUE) ? hold_v : '0;
      end
      pbbt_pkg::B_Q_SCAN: begin
        rd_addr = i_p2[AW-1:0];
        if (i_p2 < (CW + 1)'(count_r) && cmd_r.query_time > rd_t) begin
          t_lo_nxt = rd_t;
          v_lo_nxt = rd_v;
          i_nxt    = i_r + AW'(1);
        end else begin
          t_hi_nxt = rd_t;
          v_hi_nxt = rd_v;
        end
      end
      pbbt_pkg::B_Q_SEG: begin
        span_nxt  = g_span;
        dm_nxt    = g_dm;
        neg_nxt   = g_df[32];
        first_nxt = g_first;
        s_nxt     = g_first ? g_tau : (g_span - g_tau);
        if (g_span == '0 || g_df == '0) begin
          res_nxt = (cmd_r.deriv_order == pbbt_pkg::ORD_VALUE) ? hold_lo : '0;
        end else if (cmd_r.deriv_order == pbbt_pkg::ORD_ACC) begin
          res_nxt = g_first ? acc_s : -acc_s;
        end else begin
          res_nxt = '0;
        end
      end
      pbbt_pkg::B_SQ:  sq_nxt = mul_p;
      pbbt_pkg::B_SQ2: ss_nxt = mul_p;
      pbbt_pkg::B_WAIT: begin
        if (r_done) begin
          if (is_append) begin
            acc_we    = 1'b1;
            acc_wdata = part;
            count_nxt = count_r + CW'(1);
          end else if (cmd_r.deriv_order == pbbt_pkg::ORD_VALUE) begin
            res_nxt = first_r ? (hold_lo + part) : (64'(v_hi_r) - part);
          end else begin
            res_nxt = part;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbbt_pkg::B_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == pbbt_pkg::B_FIN) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // saturate into the output register
  always_ff @(posedge clk) begin
    if (state_r == pbbt_pkg::B_FIN) begin
      if (res_r > 64'(pbbt_pkg::S32_MAX)) begin
        ores_r  <= pbbt_pkg::S32_MAX;
        ostat_r <= pbbt_pkg::ST_SAT;
      end else if (res_r < 64'(pbbt_pkg::S32_MIN)) begin
        ores_r  <= pbbt_pkg::S32_MIN;
        ostat_r <= pbbt_pkg::ST_SAT;
      end else begin
        ores_r  <= res_r[31:0];
        ostat_r <= stat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    i_r     <= i_nxt;
    t_lo_r  <= t_lo_nxt;
    t_hi_r  <= t_hi_nxt;
    v_lo_r  <= v_lo_nxt;
    v_hi_r  <= v_hi_nxt;
    span_r  <= span_nxt;
    s_r     <= s_nxt;
    dm_r    <= dm_nxt;
    neg_r   <= neg_nxt;
    first_r <= first_nxt;
    sq_r    <= sq_nxt;
    ss_r    <= ss_nxt;
    res_r   <= res_nxt;
    stat_r  <= stat_nxt;
  end

  assign out_valid        = ov_r;
  assign out_result_value = ores_r;
  assign out_status       = ostat_r;

endmodule

// ===== hdl/pbbt_checker.sv =====
// Port-level checks for the trajectory block, bound to the top level.
// Depends on pbbt_pkg.
module pbbt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_result_value,
  input logic [1:0]         out_status
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_value) && $stable(out_status))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word after reset");

  // dropped append and short table give zero
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pbbt_pkg::ST_FULL || out_status == pbbt_pkg::ST_FEW)
    |-> out_result_value == 32'sd0)
    else $error("nonzero result with full or few status");

  // saturation flag only with a rail value
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pbbt_pkg::ST_SAT
    |-> out_result_value == pbbt_pkg::S32_MAX || out_result_value == pbbt_pkg::S32_MIN)
    else $error("saturated status without a rail value");

  // queue space: stall is released only once a word left or the output was empty
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !in_valid |=> in_stall || $past(out_valid && !out_stall) || !out_valid
      || $past(!out_valid))
    else $error("input stall released without progress");

endmodule

bind piecewise_bang_bang_trajectory pbbt_checker u_pbbt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_result_value(out_result_value), .out_status(out_status)
);
